// ----- hdl/spd_pkg.sv -----
// Package for the point distance sorter: field widths, register indexes,
// controller states and the command and status groups between the two halves.
// No dependencies.
package spd_pkg;

   localparam int XZ_BITS        = 26;
   localparam int Y_BITS         = 12;
   localparam int INDEX_BITS     = 6;
   localparam int Y_LSB          = XZ_BITS;
   localparam int Z_LSB          = XZ_BITS + Y_BITS;
   localparam int REQ_TDATA_BITS = 64;
   localparam int RSP_TDATA_BITS = 72;
   localparam int RSP_PAD_BITS   = RSP_TDATA_BITS - (2 * XZ_BITS + Y_BITS + INDEX_BITS);
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 26;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET_X = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET_Y = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET_Z = 2'd2;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SQX,
      ST_SQY,
      ST_SQZ,
      ST_STORE,
      ST_SCAN,
      ST_DRAIN,
      ST_FETCH,
      ST_EMIT
   } spd_state_type;

   typedef enum logic [1:0] {
      MUL_X,
      MUL_Y,
      MUL_Z
   } spd_mul_sel_type;

   typedef struct packed {
      logic            capture;
      logic            drop;
      logic            mul_en;
      spd_mul_sel_type mul_sel;
      logic            acc_clr;
      logic            acc_add;
      logic            store;
      logic            scan_read;
      logic            fetch;
      logic            advance;
      logic            finish;
   } spd_cmd_type;

   typedef struct packed {
      logic full;
      logic scan_end;
      logic rank_last;
      logic last;
   } spd_status_type;

endpackage

// ----- hdl/spd_ctrl.sv -----
// Controller of the point distance sorter: load, key and selection-scan sequence.
// Depends on spd_pkg; drives spd_datapath through command and status groups.
module spd_ctrl
   import spd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   input  logic           req_tlast,
   output logic           req_tready,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   input  spd_status_type status,
   output spd_cmd_type    cmd
);

   spd_state_type state_ff;
   spd_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_tvalid) begin
               if (status.full) begin
                  state_in = req_tlast ? ST_SCAN : ST_LOAD;
               end else begin
                  state_in = ST_SQX;
               end
            end
         end
         ST_SQX:   state_in = ST_SQY;
         ST_SQY:   state_in = ST_SQZ;
         ST_SQZ:   state_in = ST_STORE;
         ST_STORE: state_in = status.last ? ST_SCAN : ST_LOAD;
         ST_SCAN: begin
            if (status.scan_end) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_FETCH;
         ST_FETCH: state_in = ST_EMIT;
         ST_EMIT: begin
            if (rsp_tready) begin
               state_in = status.rank_last ? ST_LOAD : ST_SCAN;
            end
         end
         default:  state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.mul_sel = MUL_X;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
            cmd.drop    = req_tvalid & status.full;
         end
         ST_SQX: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_X;
            cmd.acc_clr = 1'b1;
         end
         ST_SQY: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_Y;
            cmd.acc_add = 1'b1;
         end
         ST_SQZ: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_Z;
            cmd.acc_add = 1'b1;
         end
         ST_STORE: cmd.store     = 1'b1;
         ST_SCAN:  cmd.scan_read = 1'b1;
         ST_FETCH: cmd.fetch     = 1'b1;
         ST_EMIT: begin
            rsp_tvalid  = 1'b1;
            cmd.advance = rsp_tready & ~status.rank_last;
            cmd.finish  = rsp_tready & status.rank_last;
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- hdl/spd_datapath.sv -----
// Datapath of the point distance sorter: target registers, squared-distance
// unit, point and key memories and the minimum-search scan. Depends on spd_pkg.
module spd_datapath
   import spd_pkg::*;
#(
   parameter int MAX_POINTS = 64,
   parameter int COORD_BITS = 26
) (
   input  logic                      clock,
   input  logic                      reset,
   input  spd_cmd_type               cmd,
   output spd_status_type            status,
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,
   input  logic                      req_tlast,
   input  logic                      csr_valid,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   output logic                      rsp_tlast,
   output logic                      rsp_tuser
);

   localparam int ADDR_W = $clog2(MAX_POINTS);
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int MAG_W  = (COORD_BITS > Y_BITS) ? COORD_BITS : Y_BITS;
   localparam int DIFF_W = MAG_W + 1;
   localparam int PROD_W = 2 * MAG_W;
   localparam int KEY_W  = PROD_W + 2;
   localparam int PT_W   = 2 * COORD_BITS + Y_BITS;

   logic signed [COORD_BITS-1:0] tx_ff, tz_ff;
   logic signed [Y_BITS-1:0]     ty_ff;

   logic [COORD_BITS-1:0] px_ff, pz_ff;
   logic [Y_BITS-1:0]     py_ff;
   logic signed [DIFF_W-1:0] dx_ff, dz_ff, dx_in, dz_in;
   logic signed [Y_BITS:0]   dy_ff, dy_in;
   logic                  last_ff;

   logic signed [DIFF_W-1:0] d_sel;
   logic [MAG_W-1:0]      mag;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [KEY_W-1:0]      acc_ff, acc_in, key_in;

   logic [CNT_W-1:0]      count_ff, count_in, count_m1;
   logic                  ovf_ff, ovf_in;

   logic [PT_W-1:0]       point_mem [MAX_POINTS];
   logic [KEY_W-1:0]      key_mem [MAX_POINTS];

   logic [ADDR_W-1:0]     scan_ff, scan_in;
   logic [ADDR_W-1:0]     rank_ff, rank_in;
   logic                  rd_valid_ff;
   logic [ADDR_W-1:0]     rd_idx_ff;
   logic [KEY_W-1:0]      key_rd_ff;
   logic [KEY_W-1:0]      best_key_ff, best_key_in, prev_key_ff;
   logic [ADDR_W-1:0]     best_idx_ff, best_idx_in, prev_idx_ff;
   logic                  best_found_ff, best_found_in;
   logic                  first_ff, first_in;
   logic                  cand, better;
   logic [PT_W-1:0]       point_rd_ff;

   logic [XZ_BITS-1:0]    out_x, out_z;
   logic [Y_BITS-1:0]     out_y;
   logic [INDEX_BITS-1:0] out_index;

   // target registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tx_ff <= '0;
         ty_ff <= '0;
         tz_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TARGET_X: tx_ff <= csr_data[COORD_BITS-1:0];
            CSR_TARGET_Y: ty_ff <= csr_data[Y_BITS-1:0];
            CSR_TARGET_Z: tz_ff <= csr_data[COORD_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // capture point and differences to the target
   assign dx_in = DIFF_W'($signed(req_tdata[COORD_BITS-1:0])) - DIFF_W'(tx_ff);
   assign dy_in = (Y_BITS + 1)'($signed(req_tdata[Y_LSB +: Y_BITS])) - (Y_BITS + 1)'(ty_ff);
   assign dz_in = DIFF_W'($signed(req_tdata[Z_LSB +: COORD_BITS])) - DIFF_W'(tz_ff);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         px_ff   <= req_tdata[COORD_BITS-1:0];
         py_ff   <= req_tdata[Y_LSB +: Y_BITS];
         pz_ff   <= req_tdata[Z_LSB +: COORD_BITS];
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         dz_ff   <= dz_in;
         last_ff <= req_tlast;
      end
   end

   // one shared squarer, product registered before accumulation
   always_comb begin
      case (cmd.mul_sel)
         MUL_X:   d_sel = dx_ff;
         MUL_Y:   d_sel = DIFF_W'(dy_ff);
         MUL_Z:   d_sel = dz_ff;
         default: d_sel = dx_ff;
      endcase
   end

   assign mag     = MAG_W'(d_sel[DIFF_W-1] ? -d_sel : d_sel);
   assign prod_in = PROD_W'(mag) * PROD_W'(mag);

   always_comb begin
      acc_in = acc_ff;
      if (cmd.acc_clr) begin
         acc_in = '0;
      end else if (cmd.acc_add) begin
         acc_in = acc_ff + KEY_W'(prod_ff);
      end
   end

   assign key_in = acc_ff + KEY_W'(prod_ff);

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
   end

   // set bookkeeping
   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (cmd.store) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.drop) begin
         ovf_in = 1'b1;
      end
      if (cmd.finish) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end
   end

   assign count_m1 = count_ff - CNT_W'(1);

   // memories
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         point_mem[count_ff[ADDR_W-1:0]] <= {pz_ff, py_ff, px_ff};
         key_mem[count_ff[ADDR_W-1:0]]   <= key_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_read) begin
         key_rd_ff <= key_mem[scan_ff];
         rd_idx_ff <= scan_ff;
      end
      if (cmd.fetch) begin
         point_rd_ff <= point_mem[best_idx_ff];
      end
   end

   // selection scan: smallest (key, index) above the previous rank
   assign cand   = first_ff || (key_rd_ff > prev_key_ff) ||
                   ((key_rd_ff == prev_key_ff) && (rd_idx_ff > prev_idx_ff));
   assign better = !best_found_ff || (key_rd_ff < best_key_ff);

   always_comb begin
      scan_in       = scan_ff;
      rank_in       = rank_ff;
      best_key_in   = best_key_ff;
      best_idx_in   = best_idx_ff;
      best_found_in = best_found_ff;
      first_in      = first_ff;
      if (cmd.scan_read) begin
         scan_in = status.scan_end ? '0 : scan_ff + ADDR_W'(1);
      end
      if (rd_valid_ff && cand && better) begin
         best_key_in   = key_rd_ff;
         best_idx_in   = rd_idx_ff;
         best_found_in = 1'b1;
      end
      if (cmd.advance) begin
         rank_in       = rank_ff + ADDR_W'(1);
         best_found_in = 1'b0;
         first_in      = 1'b0;
      end
      if (cmd.finish) begin
         rank_in       = '0;
         best_found_in = 1'b0;
         first_in      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         scan_ff       <= '0;
         rank_ff       <= '0;
         rd_valid_ff   <= 1'b0;
         best_found_ff <= 1'b0;
         first_ff      <= 1'b1;
      end else begin
         count_ff      <= count_in;
         ovf_ff        <= ovf_in;
         scan_ff       <= scan_in;
         rank_ff       <= rank_in;
         rd_valid_ff   <= cmd.scan_read;
         best_found_ff <= best_found_in;
         first_ff      <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      best_key_ff <= best_key_in;
      best_idx_ff <= best_idx_in;
      if (cmd.advance) begin
         prev_key_ff <= best_key_ff;
         prev_idx_ff <= best_idx_ff;
      end
   end

   assign status.full      = (count_ff == CNT_W'(MAX_POINTS));
   assign status.scan_end  = (scan_ff == count_m1[ADDR_W-1:0]);
   assign status.rank_last = (rank_ff == count_m1[ADDR_W-1:0]);
   assign status.last      = last_ff;

   // result item
   assign out_x     = XZ_BITS'($signed(point_rd_ff[COORD_BITS-1:0]));
   assign out_y     = point_rd_ff[COORD_BITS +: Y_BITS];
   assign out_z     = XZ_BITS'($signed(point_rd_ff[COORD_BITS + Y_BITS +: COORD_BITS]));
   assign out_index = INDEX_BITS'(best_idx_ff);

   assign rsp_tdata = {{RSP_PAD_BITS{1'b0}}, out_index, out_z, out_y, out_x};
   assign rsp_tlast = status.rank_last;
   assign rsp_tuser = ovf_ff;

endmodule

// ----- hdl/sort_points_by_distance.sv -----
// Point distance sorter, top level: joins spd_ctrl and spd_datapath.
// Depends on spd_pkg, spd_ctrl and spd_datapath.
//
// Points are loaded one item at a time; each accepted point goes through accept,
// three passes through the shared squarer and a key write, while a point dropped
// because the store is full is only accepted. The item marked tlast starts the
// output: for each rank the key memory is scanned once for the smallest squared
// distance above the previous rank, ties in load order, so one result
// for a set of n points takes n key reads, a drain, a point read and the result
// shown until it is taken. No new point is accepted until the last result of the
// set has been taken. Results carry the load index; tuser flags a set that lost
// points. Target registers are written through the csr port and apply to points
// loaded after the write.
module sort_points_by_distance
   import spd_pkg::*;
#(
   parameter int MAX_POINTS = 64,
   parameter int COORD_BITS = 26
) (
   input  logic                      clock,
   input  logic                      reset,
   // point_x[25:0], point_y[37:26], point_z[63:38]
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,
   input  logic                      req_tlast,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // out_x[25:0], out_y[37:26], out_z[63:38], out_index[69:64], zero[71:70]
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   output logic                      rsp_tlast,
   // overflowed[0]
   output logic                      rsp_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   spd_cmd_type    cmd;
   spd_status_type status;

   assign csr_ready = 1'b1;

   spd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   spd_datapath #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .csr_valid (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser)
   );

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for sort_points_by_distance: a directed table of point sets, then random
// sets under changing flow control, each ranked result checked against a predictor held here.
// Depends on spd_pkg and the sort_points_by_distance RTL.
module tb_top;
   import spd_pkg::*;

   localparam int CAPACITY         = 64;
   localparam int XZ_MAX           = 33554431;
   localparam int XZ_MIN           = -33554432;
   localparam int SETTLE_CYCLES    = 12;
   localparam int SHOWN_MISMATCHES = 10;

   typedef struct {
      logic signed [XZ_BITS-1:0] x;
      logic signed [Y_BITS-1:0]  y;
      logic signed [XZ_BITS-1:0] z;
   } point_type;

   typedef struct {
      point_type             pt;
      logic [INDEX_BITS-1:0] idx;
      logic                  last;
      logic                  ovf;
   } ranked_type;

   typedef struct {
      int x;
      int y;
      int z;
      bit last;
      bit retarget;
      int tx;
      int ty;
      int tz;
      bit typed;
   } dir_row_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic [REQ_TDATA_BITS-1:0] req_tdata  = '0;
   logic                      req_tlast  = 1'b0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                      rsp_tlast;
   logic                      rsp_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic                      csr_valid  = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index  = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data   = '0;

   int send_gap_pct  = 0;
   int rsp_stall_pct = 0;
   int mismatches    = 0;
   int results_seen  = 0;
   int points_taken  = 0;
   int sets_done     = 0;
   int lossy_sets    = 0;

   logic signed [XZ_BITS-1:0] aim_x = '0;
   logic signed [Y_BITS-1:0]  aim_y = '0;
   logic signed [XZ_BITS-1:0] aim_z = '0;
   point_type                 held_pts  [CAPACITY];
   longint                    held_keys [CAPACITY];
   int                        held_count   = 0;
   bit                        held_dropped = 1'b0;
   ranked_type                ranked_q [$];

   dir_row_type dir_rows [20] = '{
      '{0, 0, 0, 1, 0, 0, 0, 0, 1},
      '{XZ_MAX, 2047, XZ_MAX, 1, 0, 0, 0, 0, 1},
      '{XZ_MIN, -2048, XZ_MIN, 1, 0, 0, 0, 0, 1},
      '{-1, -1, -1, 1, 0, 0, 0, 0, 1},
      '{3, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, -3, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 3, 0, 0, 0, 0, 0, 0},
      '{1, 1, 1, 1, 0, 0, 0, 0, 0},
      '{5, 5, 5, 0, 0, 0, 0, 0, 0},
      '{-5, -5, -5, 0, 0, 0, 0, 0, 0},
      '{5, -5, 5, 1, 0, 0, 0, 0, 0},
      '{22369621, 1365, -22369622, 0, 0, 0, 0, 0, 0},
      '{-22369622, -1366, 22369621, 1, 0, 0, 0, 0, 0},
      '{XZ_MIN, -2048, XZ_MIN, 0, 1, XZ_MAX, 2047, XZ_MAX, 0},
      '{XZ_MAX, 2047, XZ_MAX, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 1, 0, 0, 0, 0, 0},
      '{XZ_MAX, 2047, XZ_MAX, 1, 1, XZ_MIN, -2048, XZ_MIN, 1},
      '{90, -7, -100, 0, 1, 100, -7, -100, 0},
      '{90, -7, -100, 0, 1, 0, 0, 0, 0},
      '{100, -7, -100, 1, 0, 0, 0, 0, 0}
   };

   sort_points_by_distance #(
      .MAX_POINTS (CAPACITY),
      .COORD_BITS (XZ_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic longint distance_key(point_type p);
      longint dx, dy, dz;
      dx = longint'(p.x) - longint'(aim_x);
      dy = longint'(p.y) - longint'(aim_y);
      dz = longint'(p.z) - longint'(aim_z);
      return dx * dx + dy * dy + dz * dz;
   endfunction

   task automatic load_point(point_type p, bit last, bit typed);
      int         order [$];
      int         pos;
      ranked_type r;
      points_taken++;
      if (held_count < CAPACITY) begin
         held_pts[held_count]  = p;
         held_keys[held_count] = distance_key(p);
         held_count++;
      end else begin
         held_dropped = 1'b1;
      end
      if (!last) return;
      sets_done++;
      if (held_dropped) lossy_sets++;
      for (int i = 0; i < held_count; i++) begin
         pos = order.size();
         while (pos > 0 && held_keys[i] < held_keys[order[pos-1]]) pos--;
         order.insert(pos, i);
      end
      if (typed) begin
         r.pt   = p;
         r.idx  = '0;
         r.last = 1'b1;
         r.ovf  = 1'b0;
         ranked_q.insert(ranked_q.size(), r);
      end else begin
         for (int i = 0; i < held_count; i++) begin
            r.pt   = held_pts[order[i]];
            r.idx  = INDEX_BITS'(order[i]);
            r.last = (i == held_count - 1);
            r.ovf  = held_dropped;
            ranked_q.insert(ranked_q.size(), r);
         end
      end
      held_count   = 0;
      held_dropped = 1'b0;
   endtask

   task automatic compare(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= SHOWN_MISMATCHES)
            $display("mismatch on %s at result %0d: expected %h, got %h",
                     field, results_seen, want, got);
      end
   endtask

   task automatic check_result();
      ranked_type e;
      results_seen++;
      if (ranked_q.size() == 0) begin
         mismatches++;
         if (mismatches <= SHOWN_MISMATCHES)
            $display("unexpected result %0d: tdata %h", results_seen, rsp_tdata);
         return;
      end
      e = ranked_q.pop_front();
      compare("x", $unsigned(e.pt.x), rsp_tdata[XZ_BITS-1:0]);
      compare("y", $unsigned(e.pt.y), rsp_tdata[Y_LSB +: Y_BITS]);
      compare("z", $unsigned(e.pt.z), rsp_tdata[Z_LSB +: XZ_BITS]);
      compare("index", e.idx, rsp_tdata[Z_LSB + XZ_BITS +: INDEX_BITS]);
      compare("padding", '0, rsp_tdata[RSP_TDATA_BITS-1 -: RSP_PAD_BITS]);
      compare("last", e.last, rsp_tlast);
      compare("overflowed", e.ovf, rsp_tuser);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   task automatic settle();
      req_tvalid <= 1'b0;
      while (ranked_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_target(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_TARGET_X: aim_x = data;
         CSR_TARGET_Y: aim_y = data[Y_BITS-1:0];
         CSR_TARGET_Z: aim_z = data;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_targets(int tx, int ty, int tz);
      settle();
      write_target(CSR_TARGET_X, tx[CSR_DATA_BITS-1:0]);
      write_target(CSR_TARGET_Y, ty[CSR_DATA_BITS-1:0]);
      write_target(CSR_TARGET_Z, tz[CSR_DATA_BITS-1:0]);
   endtask

   task automatic send_point(point_type p, bit last, bit typed);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {p.z, p.y, p.x};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      load_point(p, last, typed);
   endtask

   function automatic int pick_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 6);
      if (r < 95) return $urandom_range(7, 16);
      return $urandom_range(CAPACITY - 4, CAPACITY + 2);
   endfunction

   // mix of wide points, points clustered on the target and repeats to force ties
   function automatic point_type random_point(point_type prev);
      point_type p;
      case ($urandom_range(0, 2))
         0: begin
            p.x = XZ_BITS'($urandom());
            p.y = Y_BITS'($urandom());
            p.z = XZ_BITS'($urandom());
         end
         1: begin
            p.x = XZ_BITS'(aim_x + int'($urandom_range(0, 6)) - 3);
            p.y = Y_BITS'(aim_y + int'($urandom_range(0, 6)) - 3);
            p.z = XZ_BITS'(aim_z + int'($urandom_range(0, 6)) - 3);
         end
         default: p = prev;
      endcase
      return p;
   endfunction

   task automatic run_random(int budget, int forced);
      int                        sent;
      int                        size;
      int                        pick;
      logic [CSR_INDEX_BITS-1:0] idx;
      point_type                 p;
      sent = 0;
      p.x  = '0;
      p.y  = '0;
      p.z  = '0;
      while (sent < budget) begin
         size = (forced != 0 && sent == 0) ? forced : pick_size();
         if (size > budget - sent) size = budget - sent;
         for (int k = 0; k < size; k++) begin
            if (k == 1 && $urandom_range(0, 7) == 0) begin
               settle();
               pick = $urandom_range(0, 2);
               idx  = (pick == 0) ? CSR_TARGET_X : (pick == 1) ? CSR_TARGET_Y : CSR_TARGET_Z;
               write_target(idx, CSR_DATA_BITS'($urandom()));
            end
            p = random_point(p);
            send_point(p, k == size - 1, 1'b0);
         end
         sent += size;
      end
   endtask

   initial begin
      #8_000_000;
      $display("run timed out with %0d results outstanding", ranked_q.size());
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      dir_row_type row;
      point_type   p;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_gap_pct  = 9;
      rsp_stall_pct = 62;
      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         if (row.retarget) set_targets(row.tx, row.ty, row.tz);
         p.x = row.x[XZ_BITS-1:0];
         p.y = row.y[Y_BITS-1:0];
         p.z = row.z[XZ_BITS-1:0];
         send_point(p, row.last, row.typed);
      end
      set_targets($urandom(), $urandom(), $urandom());
      run_random(70, 0);

      send_gap_pct  = 62;
      rsp_stall_pct = 9;
      set_targets($urandom(), $urandom(), $urandom());
      run_random(90, CAPACITY + 2);

      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      set_targets($urandom(), $urandom(), $urandom());
      run_random(85, CAPACITY);

      settle();
      if (ranked_q.size() != 0) begin
         mismatches++;
         $display("%0d expected results never arrived", ranked_q.size());
      end
      $display("%0d points in %0d sets ranked into %0d results, %0d sets lost points",
               points_taken, sets_done, results_seen, lossy_sets);
      $display("%0d mismatches", mismatches);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
